// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/tmqs_pkg.sv -----
// ----------------------------------------------------------------------------
// tmqs_pkg
// Types, constants and match helper for the typed message queue.
// ----------------------------------------------------------------------------
package tmqs_pkg;

  localparam int TYPE_W      = 31;
  localparam int SEL_W       = 32;
  localparam int HANDLE_W    = 32;
  localparam int REQ_LEN_W   = 16;
  localparam int LEN_W       = 14;
  localparam int MSGCNT_W    = 10;
  localparam int BYTES_W     = 23;
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 120;
  localparam int ENT_W       = TYPE_W + HANDLE_W + LEN_W;

  localparam int DEF_QUEUE_DEPTH = 512;
  localparam int DEF_MAX_LENGTH  = 8192;
  localparam logic [REQ_LEN_W-1:0] CFG_MAX_RESET = 16'd16384;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TOO_LONG = 3'd1,
    ST_FULL     = 3'd2,
    ST_NO_MATCH = 3'd3,
    ST_BUFFER   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    MM_ANY,
    MM_EQ,
    MM_NE,
    MM_LE
  } match_mode_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_RD,
    BS_CMP,
    BS_SH_RD,
    BS_SH_WR,
    BS_DONE
  } back_state_t;

  // Classified request handed from front to back.
  // key: send -> message type; receive -> selector or magnitude.
  typedef struct packed {
    logic                  is_recv;
    logic                  too_long;
    match_mode_t           mode;
    logic [SEL_W-1:0]      key;
    logic [HANDLE_W-1:0]   handle;
    logic [REQ_LEN_W-1:0]  len;
    logic                  noerror;
  } cmd_t;

  function automatic logic type_hit(logic [TYPE_W-1:0] t, match_mode_t m,
                                    logic [SEL_W-1:0] key);
    logic hit;
    unique case (m)
      MM_ANY:  hit = 1'b1;
      MM_EQ:   hit = ({1'b0, t} == key);
      MM_NE:   hit = ({1'b0, t} != key);
      MM_LE:   hit = ({1'b0, t} <= key);
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ----- hw/rtl/typed_message_queue_select_top.sv -----
// ----------------------------------------------------------------------------
// typed_message_queue_select_top
// Ordered message descriptor store with typed selective receive.
// ----------------------------------------------------------------------------
// Each request yields one result transaction. A send is executed in the back
// end and then handed to the output register. A receive reads the descriptor
// memory one entry at a time, a read and then a compare, while searching for
// the oldest match, then compacts the entries behind it, each with a read and
// a write. A two-entry request queue lets new requests be taken while the
// back end works and while a result waits.
module typed_message_queue_select_top
  import tmqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // send_type, wanted_type, payload_handle, length, except_flag, noerror_flag
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // req_type
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status, got_type, got_handle, got_length, msg_count, byte_count
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [REQ_LEN_W-1:0]   cfg_wr_data
);

  logic [REQ_LEN_W-1:0] max_bytes_r;
  logic                 cmd_valid, cmd_pop;
  cmd_t                 cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= CFG_MAX_RESET;
    end else if (cfg_wr_en) begin
      max_bytes_r <= cfg_wr_data;
    end
  end

  tmqs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_max   (max_bytes_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tmqs_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- hw/rtl/tmqs_front.sv -----
// ----------------------------------------------------------------------------
// tmqs_front
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module tmqs_front
  import tmqs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  logic [REQ_LEN_W-1:0]  cfg_max,
  output logic                  cmd_valid,
  output cmd_t                  cmd,
  input  logic                  cmd_pop
);

  logic [TYPE_W-1:0]    f_type;
  logic [SEL_W-1:0]     f_sel;
  logic [HANDLE_W-1:0]  f_handle;
  logic [REQ_LEN_W-1:0] f_len;
  logic                 f_except;
  logic                 f_noerror;
  cmd_t                 cls;

  cmd_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign f_type    = in_tdata[30:0];
  assign f_sel     = in_tdata[62:31];
  assign f_handle  = in_tdata[94:63];
  assign f_len     = in_tdata[110:95];
  assign f_except  = in_tdata[111];
  assign f_noerror = in_tdata[112];

  always_comb begin
    cls.is_recv  = in_tuser;
    cls.too_long = (f_len > cfg_max) || (f_len > REQ_LEN_W'(DEF_MAX_LENGTH));
    cls.handle   = f_handle;
    cls.len      = f_len;
    cls.noerror  = f_noerror;
    cls.mode     = MM_ANY;
    cls.key      = f_sel;
    if (!in_tuser) begin
      cls.key = {1'b0, f_type};
    end else if (f_sel == '0) begin
      cls.mode = MM_ANY;
    end else if (f_sel[SEL_W-1]) begin
      // negative selector: compare against magnitude (2^31 fits unsigned)
      cls.mode = MM_LE;
      cls.key  = ~f_sel + 1'b1;
    end else if (f_except) begin
      cls.mode = MM_NE;
    end else begin
      cls.mode = MM_EQ;
    end
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (cmd_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

// ----- hw/rtl/tmqs_back.sv -----
// ----------------------------------------------------------------------------
// tmqs_back
// Descriptor store and request sequencer: append, ordered search, compaction.
// ----------------------------------------------------------------------------
module tmqs_back
  import tmqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  input  cmd_t                   cmd,
  output logic                   cmd_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [ENT_W-1:0] mem [QUEUE_DEPTH];
  logic [ENT_W-1:0] rdata_r;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_wa, mem_ra;
  logic [ENT_W-1:0] mem_wd;

  back_state_t          state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [BYTES_W-1:0]   bytes_r, bytes_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  status_t              st_r, st_nxt;
  logic [TYPE_W-1:0]    gtype_r, gtype_nxt;
  logic [HANDLE_W-1:0]  ghandle_r, ghandle_nxt;
  logic [LEN_W-1:0]     glen_r, glen_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]   out_data_r, out_data_nxt;

  logic [TYPE_W-1:0]   ent_type;
  logic [HANDLE_W-1:0] ent_handle;
  logic [LEN_W-1:0]    ent_len;
  logic [CNT_W-1:0]    idx_p1;
  logic                ent_big;

  assign ent_type   = rdata_r[ENT_W-1 -: TYPE_W];
  assign ent_handle = rdata_r[LEN_W +: HANDLE_W];
  assign ent_len    = rdata_r[LEN_W-1:0];
  assign idx_p1     = idx_r + 1'b1;
  assign ent_big    = {{(REQ_LEN_W-LEN_W){1'b0}}, ent_len} > cmd_r.len;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_r <= mem[mem_ra];
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    count_nxt     = count_r;
    bytes_nxt     = bytes_r;
    idx_nxt       = idx_r;
    st_nxt        = st_r;
    gtype_nxt     = gtype_r;
    ghandle_nxt   = ghandle_r;
    glen_nxt      = glen_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_wa        = idx_r[AW-1:0];
    mem_ra        = idx_r[AW-1:0];
    mem_wd        = rdata_r;

    unique case (state_r)
      BS_IDLE: begin
        if (cmd_valid) begin
          cmd_pop     = 1'b1;
          cmd_nxt     = cmd;
          gtype_nxt   = '0;
          ghandle_nxt = '0;
          glen_nxt    = '0;
          idx_nxt     = '0;
          st_nxt      = ST_OK;
          state_nxt   = BS_DONE;
          if (!cmd.is_recv) begin
            if (cmd.too_long) begin
              st_nxt = ST_TOO_LONG;
            end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
              st_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_wa    = count_r[AW-1:0];
              mem_wd    = {cmd.key[TYPE_W-1:0], cmd.handle, cmd.len[LEN_W-1:0]};
              count_nxt = count_r + 1'b1;
              bytes_nxt = bytes_r + BYTES_W'(cmd.len);
            end
          end else if (count_r == '0) begin
            st_nxt = ST_NO_MATCH;
          end else begin
            state_nxt = BS_RD;
          end
        end
      end
      BS_RD: begin
        mem_re    = 1'b1;
        state_nxt = BS_CMP;
      end
      BS_CMP: begin
        if (type_hit(ent_type, cmd_r.mode, cmd_r.key)) begin
          if (ent_big && !cmd_r.noerror) begin
            st_nxt    = ST_BUFFER;
            state_nxt = BS_DONE;
          end else begin
            gtype_nxt   = ent_type;
            ghandle_nxt = ent_handle;
            glen_nxt    = ent_big ? cmd_r.len[LEN_W-1:0] : ent_len;
            bytes_nxt   = bytes_r - BYTES_W'(ent_len);
            if (idx_p1 == count_r) begin
              count_nxt = count_r - 1'b1;
              state_nxt = BS_DONE;
            end else begin
              state_nxt = BS_SH_RD;
            end
          end
        end else if (idx_p1 == count_r) begin
          st_nxt    = ST_NO_MATCH;
          state_nxt = BS_DONE;
        end else begin
          idx_nxt   = idx_p1;
          state_nxt = BS_RD;
        end
      end
      BS_SH_RD: begin
        mem_re    = 1'b1;
        mem_ra    = idx_p1[AW-1:0];
        state_nxt = BS_SH_WR;
      end
      BS_SH_WR: begin
        mem_we  = 1'b1;
        idx_nxt = idx_p1;
        if (idx_p1 + 1'b1 == count_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = BS_DONE;
        end else begin
          state_nxt = BS_SH_RD;
        end
      end
      BS_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'b0, bytes_r, MSGCNT_W'(count_r), glen_r, ghandle_r,
                           gtype_r, st_r};
          state_nxt     = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      count_r     <= '0;
      bytes_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      bytes_r     <= bytes_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    st_r       <= st_nxt;
    gtype_r    <= gtype_nxt;
    ghandle_r  <= ghandle_nxt;
    glen_r     <= glen_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- hw/rtl/tmqs_checker.sv -----
// ----------------------------------------------------------------------------
// tmqs_checker
// Port-level checks for the typed message queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmqs_checker
  import tmqs_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  `ASSERT_ALWAYS(a_rst_no_out, clk, !rst_n |=> !out_tvalid, "result valid after reset")
  `ASSERT_CLK(a_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `ASSERT_CLK(a_status_rng, clk, rst_n, out_tvalid |-> out_tdata[2:0] <= ST_BUFFER, "status code out of range")
  `ASSERT_CLK(a_fail_zero, clk, rst_n, out_tvalid && out_tdata[2:0] != ST_OK |-> out_tdata[79:3] == '0, "failed request returned message fields")

endmodule

bind typed_message_queue_select_top tmqs_checker u_tmqs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- test/tmqs_checker.sv -----
// ----------------------------------------------------------------------------
// tmqs_scoreboard
// Watches the request, result and register ports of the typed message queue.
// It keeps its own descriptor store, works out the result of every accepted
// request, and compares results field by field in arrival order.
// ----------------------------------------------------------------------------
module tmqs_scoreboard
  import tmqs_pkg::*;
#(
  parameter int DEPTH   = 512,
  parameter int LEN_CAP = 8192
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [REQ_LEN_W-1:0]   cfg_wr_data,
  output int                     fail_count,
  output int                     pending_results,
  output int                     held_msgs
);

  typedef struct {
    logic [TYPE_W-1:0]   mtype;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    len;
  } descr_t;

  typedef struct {
    status_t              status;
    logic [TYPE_W-1:0]    got_type;
    logic [HANDLE_W-1:0]  got_handle;
    logic [LEN_W-1:0]     got_len;
    logic [MSGCNT_W-1:0]  msg_cnt;
    logic [BYTES_W-1:0]   byte_cnt;
  } reply_t;

  descr_t              store_q[$];
  reply_t              reply_q[$];
  logic [BYTES_W-1:0]  held_bytes;
  logic [REQ_LEN_W-1:0] max_bytes;

  assign pending_results = reply_q.size();
  assign held_msgs       = store_q.size();

  function automatic bit selects(logic [TYPE_W-1:0] t, logic [SEL_W-1:0] sel,
                                 bit except);
    logic [SEL_W-1:0] mag;
    if (sel == '0) return 1'b1;
    if (sel[SEL_W-1]) begin
      mag = ~sel + 1'b1;  // most negative selector gives 2^31
      return {1'b0, t} <= mag;
    end
    if (except) return {1'b0, t} != sel;
    return {1'b0, t} == sel;
  endfunction

  function automatic reply_t serve_request(bit is_recv, logic [IN_TDATA_W-1:0] d);
    logic [TYPE_W-1:0]    mt;
    logic [SEL_W-1:0]     sel;
    logic [HANDLE_W-1:0]  h;
    logic [REQ_LEN_W-1:0] len;
    bit                   ex, ne;
    int                   hit;
    reply_t               r;
    mt  = d[30:0];
    sel = d[62:31];
    h   = d[94:63];
    len = d[110:95];
    ex  = d[111];
    ne  = d[112];
    r = '{ST_OK, '0, '0, '0, '0, '0};
    if (!is_recv) begin
      if (len > max_bytes || len > LEN_CAP) r.status = ST_TOO_LONG;
      else if (store_q.size() >= DEPTH) r.status = ST_FULL;
      else begin
        store_q.push_back('{mt, h, len[LEN_W-1:0]});
        held_bytes = held_bytes + BYTES_W'(len);
      end
    end else begin
      hit = -1;
      foreach (store_q[i])
        if (hit < 0 && selects(store_q[i].mtype, sel, ex)) hit = i;
      if (hit < 0) r.status = ST_NO_MATCH;
      else if (store_q[hit].len > len && !ne) r.status = ST_BUFFER;
      else begin
        r.got_type   = store_q[hit].mtype;
        r.got_handle = store_q[hit].handle;
        r.got_len    = (store_q[hit].len > len) ? len[LEN_W-1:0] : store_q[hit].len;
        // byte total drops by the original length even when truncated
        held_bytes = held_bytes - BYTES_W'(store_q[hit].len);
        store_q.delete(hit);
      end
    end
    r.msg_cnt  = MSGCNT_W'(store_q.size());
    r.byte_cnt = held_bytes;
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t exp_r;
    reply_t act;
    if (!rst_n) begin
      store_q.delete();
      reply_q.delete();
      held_bytes = '0;
      max_bytes  = CFG_MAX_RESET;
      fail_count = 0;
    end else begin
      if (cfg_wr_en) max_bytes = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        act.status     = status_t'(out_tdata[2:0]);
        act.got_type   = out_tdata[33:3];
        act.got_handle = out_tdata[65:34];
        act.got_len    = out_tdata[79:66];
        act.msg_cnt    = out_tdata[89:80];
        act.byte_cnt   = out_tdata[112:90];
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result transaction, actual %p", $time, act);
          fail_count++;
        end else begin
          exp_r = reply_q.pop_front();
          if (act.status !== exp_r.status || act.got_type !== exp_r.got_type ||
              act.got_handle !== exp_r.got_handle || act.got_len !== exp_r.got_len ||
              act.msg_cnt !== exp_r.msg_cnt || act.byte_cnt !== exp_r.byte_cnt) begin
            $display("%0t: result mismatch, expected %p actual %p", $time, exp_r, act);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) reply_q.push_back(serve_request(in_tuser, in_tdata));
    end
  end

endmodule

// ----- test/typed_message_queue_select_top_tb.sv -----
// ----------------------------------------------------------------------------
// typed_message_queue_select_top_tb
// Drives send and receive requests into the typed message queue under varying
// handshake pressure and length limits; the checker scores every result.
// ----------------------------------------------------------------------------
module typed_message_queue_select_top_tb;
  import tmqs_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [REQ_LEN_W-1:0]   cfg_wr_data = '0;

  int fail_count, pending_results, held_msgs;
  int src_idle_pct = 0;
  int dst_stall_pct = 0;
  int hold_cycles = 0;
  int sent_items = 0;

  localparam bit REQ_SEND = 1'b0;
  localparam bit REQ_RECV = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typed_message_queue_select_top u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_wr_en, .cfg_wr_data
  );

  tmqs_scoreboard u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_wr_en, .cfg_wr_data,
    .fail_count, .pending_results, .held_msgs
  );

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_tready  <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= dst_stall_pct);
    end
  end

  task automatic push_request(bit req, logic [TYPE_W-1:0] mt, logic [SEL_W-1:0] sel,
                              logic [HANDLE_W-1:0] h, logic [REQ_LEN_W-1:0] len,
                              bit ex, bit ne);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {7'b0, ne, ex, len, h, sel, mt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
  endtask

  task automatic settle_and_set_limit(logic [REQ_LEN_W-1:0] limit);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [TYPE_W-1:0] pick_type();
    case ($urandom_range(9))
      0:       return TYPE_W'($urandom);
      1:       return 31'h7FFF_FFFF;
      default: return TYPE_W'($urandom_range(7));
    endcase
  endfunction

  function automatic logic [SEL_W-1:0] pick_selector();
    case ($urandom_range(9))
      0, 1:    return '0;
      2, 3:    return SEL_W'(-$urandom_range(1, 7));
      4:       return 32'h8000_0000;
      5:       return SEL_W'($urandom);
      default: return SEL_W'($urandom_range(1, 7));
    endcase
  endfunction

  task automatic random_request(logic [REQ_LEN_W-1:0] limit);
    bit send_now;
    logic [REQ_LEN_W-1:0] len;
    send_now = (held_msgs < 24) ? ($urandom_range(99) < 55) : ($urandom_range(99) < 30);
    case ($urandom_range(9))
      0:       len = REQ_LEN_W'($urandom);
      1:       len = REQ_LEN_W'(limit + $urandom_range(0, 3) - 1);
      default: len = REQ_LEN_W'($urandom_range(0, 600));
    endcase
    if (send_now)
      push_request(REQ_SEND, pick_type(), SEL_W'($urandom), HANDLE_W'($urandom), len,
                   1'($urandom), 1'($urandom));
    else
      push_request(REQ_RECV, TYPE_W'($urandom), pick_selector(), HANDLE_W'($urandom),
                   ($urandom_range(3) == 0) ? REQ_LEN_W'($urandom_range(0, 300)) : len,
                   1'($urandom), 1'($urandom));
  endtask

  initial begin
    logic [REQ_LEN_W-1:0] limits[4] = '{16'd8192, 16'd65535, 16'd300, 16'd0};
    int pct[4][2] = '{'{0, 0}, '{60, 0}, '{0, 60}, '{15, 15}};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: limits, type zero, selector forms, truncation, no match
    push_request(REQ_RECV, '0, '0, '0, 16'd100, 1'b0, 1'b0);
    push_request(REQ_SEND, '0, '0, 32'hFFFF_FFFF, 16'd0, 1'b0, 1'b0);
    push_request(REQ_SEND, 31'h7FFF_FFFF, '1, 32'h0, 16'd8192, 1'b1, 1'b1);
    push_request(REQ_SEND, 31'd5, '0, 32'h1234_5678, 16'd8193, 1'b0, 1'b0);
    push_request(REQ_SEND, 31'd5, '0, 32'hA5A5_5A5A, 16'd65535, 1'b0, 1'b0);
    push_request(REQ_SEND, 31'd3, '0, 32'hCAFE_0003, 16'd40, 1'b0, 1'b0);
    push_request(REQ_SEND, 31'd9, '0, 32'hCAFE_0009, 16'd500, 1'b0, 1'b0);
    push_request(REQ_RECV, '0, 32'd9, '0, 16'd499, 1'b0, 1'b0);
    push_request(REQ_RECV, '0, 32'd9, '0, 16'd10, 1'b0, 1'b1);
    push_request(REQ_RECV, '0, 32'd7, '0, 16'd65535, 1'b0, 1'b0);
    push_request(REQ_RECV, '0, 32'd3, '0, 16'd65535, 1'b1, 1'b0);
    push_request(REQ_RECV, '0, -32'sd4, '0, 16'd65535, 1'b1, 1'b0);
    push_request(REQ_RECV, '0, 32'h8000_0000, '0, 16'd65535, 1'b0, 1'b1);
    push_request(REQ_RECV, '0, -32'sd1, '0, 16'd0, 1'b0, 1'b0);
    push_request(REQ_RECV, '0, '0, '0, 16'd65535, 1'b0, 1'b0);

    // fill the store, overflow it, then drain
    settle_and_set_limit(16'd8192);
    for (int i = 0; i < 512; i++)
      push_request(REQ_SEND, pick_type(), SEL_W'($urandom), HANDLE_W'($urandom),
                   (i % 64 == 0) ? 16'd8192 : 16'($urandom_range(0, 200)), 1'b0, 1'b0);
    push_request(REQ_SEND, 31'd1, '0, '0, 16'd10, 1'b0, 1'b0);
    push_request(REQ_SEND, 31'd1, '0, '0, 16'd9000, 1'b0, 1'b0);
    for (int i = 0; i < 512; i++)
      push_request(REQ_RECV, '0, '0, '0, 16'd65535, 1'b0, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      settle_and_set_limit(limits[ph]);
      src_idle_pct  = pct[ph][0];
      dst_stall_pct = pct[ph][1];
      if (ph == 0) begin
        hold_cycles = 400;  // result side blocked while requests keep coming
        for (int i = 0; i < 40; i++)
          push_request(REQ_SEND, pick_type(), '0, HANDLE_W'($urandom), 16'd10, 1'b0, 1'b0);
      end
      for (int i = 0; i < 100; i++) random_request(limits[ph]);
    end
    settle_and_set_limit(CFG_MAX_RESET);
    src_idle_pct  = 0;
    dst_stall_pct = 0;
    for (int i = 0; i < 20; i++) random_request(CFG_MAX_RESET);

    in_tvalid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d requests: full store and drain, five length limits,", sent_items);
    $display("all selector forms, truncation, and four handshake pressure mixes.");
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #50000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/tmqs_pkg.sv
hw/rtl/tmqs_front.sv
hw/rtl/tmqs_back.sv
hw/rtl/typed_message_queue_select_top.sv
hw/rtl/tmqs_checker.sv
test/tmqs_checker.sv
test/typed_message_queue_select_top_tb.sv
